[hdl/tcpq_pkg.sv]
// shared types and constants for the three-class packet ring queues
`timescale 1ns / 1ps
package tcpq_pkg;

   localparam int ID_W      = 16;
   localparam int SIZE_W    = 16;
   localparam int PRIO_W    = 3;
   localparam int ENTRY_W   = ID_W + SIZE_W + PRIO_W;
   localparam int TOTAL_W   = 22;
   localparam int CLASS_W   = 2;
   localparam int FUNC_W    = 2;

   localparam logic [CLASS_W-1:0] NUM_CLASSES = 2'd3;
   localparam logic [CLASS_W-1:0] CLASS_HIGH  = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_MED   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_LOW   = 2'd2;

   typedef enum logic [FUNC_W-1:0] {
      FN_ENQ    = 2'd0,
      FN_DEQ    = 2'd1,
      FN_SEARCH = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DEQ,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clear_res;
      logic set_full;
      logic set_empty;
      logic enq_commit;
      logic rd_issue;
      logic rd_next;
      logic idx_clear;
      logic idx_inc;
      logic deq_commit;
      logic set_found;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      func_type op;
      logic     op_valid;
      logic     class_ok;
      logic     full;
      logic     empty;
      logic     match;
      logic     scan_last;
   } sts_type;

endpackage

[hdl/tcpq_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module tcpq_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tcpq_dp.sv]
// datapath: request registers, queue pointers, entry memory, running total, result registers
`timescale 1ns / 1ps
module tcpq_dp #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tcpq_pkg::cmd_type                   cmd,
   output tcpq_pkg::sts_type                   sts,
   input  logic [tcpq_pkg::FUNC_W-1:0]         req_func,
   input  logic [tcpq_pkg::CLASS_W-1:0]        req_queue_class,
   input  logic [tcpq_pkg::ID_W-1:0]           req_packet_id,
   input  logic [tcpq_pkg::SIZE_W-1:0]         req_packet_size,
   input  logic signed [tcpq_pkg::PRIO_W-1:0]  req_packet_priority,
   output logic [1:0]                          rsp_status,
   output logic [tcpq_pkg::ID_W-1:0]           rsp_out_id,
   output logic [tcpq_pkg::SIZE_W-1:0]         rsp_out_size,
   output logic signed [tcpq_pkg::PRIO_W-1:0]  rsp_out_priority,
   output logic                                rsp_found,
   output logic [tcpq_pkg::TOTAL_W-1:0]        rsp_occupied_total
);

   localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = SW + 1;
   localparam int RAM_DEPTH = 3 * QUEUE_DEPTH;
   localparam int AW = $clog2(RAM_DEPTH);
   localparam int EW = tcpq_pkg::ENTRY_W;
   localparam int TW = tcpq_pkg::TOTAL_W;
   localparam logic [PW-1:0] DEPTH_P = PW'(QUEUE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] BASE_MED = AW'(QUEUE_DEPTH);
   localparam logic [AW-1:0] BASE_LOW = AW'(2 * QUEUE_DEPTH);

   // request registers
   logic [tcpq_pkg::FUNC_W-1:0]  op_ff;
   logic [tcpq_pkg::CLASS_W-1:0] cls_ff;
   logic [tcpq_pkg::ID_W-1:0]    id_ff;
   logic [tcpq_pkg::SIZE_W-1:0]  size_ff;
   logic [tcpq_pkg::PRIO_W-1:0]  prio_ff;

   // queue state
   logic [SW-1:0] head_ff  [3];
   logic [SW-1:0] head_in  [3];
   logic [CW-1:0] count_ff [3];
   logic [CW-1:0] count_in [3];
   logic [TW-1:0] sum_ff;
   logic [TW-1:0] sum_in;
   logic [SW-1:0] idx_ff;
   logic [SW-1:0] idx_in;

   // result and output registers
   logic [1:0]                   res_status_ff;
   logic [tcpq_pkg::ID_W-1:0]    res_id_ff;
   logic [tcpq_pkg::SIZE_W-1:0]  res_size_ff;
   logic [tcpq_pkg::PRIO_W-1:0]  res_prio_ff;
   logic                         res_found_ff;
   logic [1:0]                   out_status_ff;
   logic [tcpq_pkg::ID_W-1:0]    out_id_ff;
   logic [tcpq_pkg::SIZE_W-1:0]  out_size_ff;
   logic [tcpq_pkg::PRIO_W-1:0]  out_prio_ff;
   logic                         out_found_ff;
   logic [TW-1:0]                out_total_ff;

   logic                          class_ok;
   logic [tcpq_pkg::CLASS_W-1:0]  qsel;
   logic [SW-1:0]                 cur_head;
   logic [CW-1:0]                 cur_count;
   logic [PW-1:0]                 tail_raw;
   logic [SW-1:0]                 tail_slot;
   logic [PW-1:0]                 rd_off;
   logic [PW-1:0]                 rd_raw;
   logic [SW-1:0]                 rd_slot;
   logic [PW-1:0]                 head_raw;
   logic [SW-1:0]                 head_next;
   logic [AW-1:0]                 base;
   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 rd_addr;
   logic [EW-1:0]                 wr_data;
   logic [EW-1:0]                 rd_data;
   logic [tcpq_pkg::ID_W-1:0]     rd_id;
   logic [tcpq_pkg::SIZE_W-1:0]   rd_size;
   logic [tcpq_pkg::PRIO_W-1:0]   rd_prio;

   assign class_ok  = cls_ff < tcpq_pkg::NUM_CLASSES;
   assign qsel      = class_ok ? cls_ff : tcpq_pkg::CLASS_HIGH;
   assign cur_head  = head_ff[qsel];
   assign cur_count = count_ff[qsel];

   assign tail_raw  = PW'(cur_head) + PW'(cur_count);
   assign tail_slot = (tail_raw >= DEPTH_P) ? SW'(tail_raw - DEPTH_P) : SW'(tail_raw);
   assign rd_off    = cmd.rd_next ? (PW'(idx_ff) + PW'(1)) : '0;
   assign rd_raw    = PW'(cur_head) + rd_off;
   assign rd_slot   = (rd_raw >= DEPTH_P) ? SW'(rd_raw - DEPTH_P) : SW'(rd_raw);
   assign head_raw  = PW'(cur_head) + PW'(1);
   assign head_next = (head_raw >= DEPTH_P) ? SW'(head_raw - DEPTH_P) : SW'(head_raw);

   always_comb begin
      unique case (qsel)
         tcpq_pkg::CLASS_MED: base = BASE_MED;
         tcpq_pkg::CLASS_LOW: base = BASE_LOW;
         default:             base = '0;
      endcase
   end

   assign wr_addr = base + AW'(tail_slot);
   assign rd_addr = base + AW'(rd_slot);
   assign wr_data = {id_ff, size_ff, prio_ff};

   tcpq_ram #(
      .WIDTH (EW),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.enq_commit),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_id   = rd_data[EW-1 -: tcpq_pkg::ID_W];
   assign rd_size = rd_data[tcpq_pkg::PRIO_W +: tcpq_pkg::SIZE_W];
   assign rd_prio = rd_data[tcpq_pkg::PRIO_W-1:0];

   assign sts.op        = tcpq_pkg::func_type'(op_ff);
   assign sts.op_valid  = (op_ff == tcpq_pkg::FN_ENQ) || (op_ff == tcpq_pkg::FN_DEQ) ||
                          (op_ff == tcpq_pkg::FN_SEARCH);
   assign sts.class_ok  = class_ok;
   assign sts.full      = cur_count == DEPTH_C;
   assign sts.empty     = cur_count == '0;
   assign sts.match     = rd_id == id_ff;
   assign sts.scan_last = (PW'(idx_ff) + PW'(1)) == PW'(cur_count);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      idx_in   = idx_ff;
      if (cmd.enq_commit) begin
         count_in[qsel] = cur_count + CW'(1);
         sum_in         = sum_ff + TW'(size_ff);
      end
      if (cmd.deq_commit) begin
         head_in[qsel]  = head_next;
         count_in[qsel] = cur_count - CW'(1);
         sum_in         = sum_ff - TW'(rd_size);
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + SW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load_req) begin
         op_ff   <= req_func;
         cls_ff  <= req_queue_class;
         id_ff   <= req_packet_id;
         size_ff <= req_packet_size;
         prio_ff <= req_packet_priority;
      end
      if (cmd.clear_res) begin
         res_id_ff    <= '0;
         res_size_ff  <= '0;
         res_prio_ff  <= '0;
         res_found_ff <= 1'b0;
         if (cmd.set_full) begin
            res_status_ff <= tcpq_pkg::STAT_FULL;
         end else if (cmd.set_empty) begin
            res_status_ff <= tcpq_pkg::STAT_EMPTY;
         end else begin
            res_status_ff <= tcpq_pkg::STAT_OK;
         end
      end
      if (cmd.deq_commit) begin
         res_id_ff   <= rd_id;
         res_size_ff <= rd_size;
         res_prio_ff <= rd_prio;
      end
      if (cmd.set_found) begin
         res_found_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_id_ff     <= res_id_ff;
         out_size_ff   <= res_size_ff;
         out_prio_ff   <= res_prio_ff;
         out_found_ff  <= res_found_ff;
         out_total_ff  <= sum_ff;
      end
   end

   assign rsp_status         = out_status_ff;
   assign rsp_out_id         = out_id_ff;
   assign rsp_out_size       = out_size_ff;
   assign rsp_out_priority   = out_prio_ff;
   assign rsp_found          = out_found_ff;
   assign rsp_occupied_total = out_total_ff;

endmodule

[hdl/tcpq_ctrl.sv]
// controller: request sequencing state machine and response valid
`timescale 1ns / 1ps
module tcpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tcpq_pkg::sts_type sts,
   output tcpq_pkg::cmd_type cmd
);

   tcpq_pkg::state_type state_ff;
   tcpq_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tcpq_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = tcpq_pkg::S_EXEC;
            end
         end
         tcpq_pkg::S_EXEC: begin
            cmd.clear_res = 1'b1;
            state_in      = tcpq_pkg::S_FINISH;
            if (sts.class_ok && sts.op_valid) begin
               unique case (sts.op)
                  tcpq_pkg::FN_ENQ: begin
                     if (sts.full) begin
                        cmd.set_full = 1'b1;
                     end else begin
                        cmd.enq_commit = 1'b1;
                     end
                  end
                  tcpq_pkg::FN_DEQ: begin
                     if (sts.empty) begin
                        cmd.set_empty = 1'b1;
                     end else begin
                        cmd.rd_issue = 1'b1;
                        state_in     = tcpq_pkg::S_DEQ;
                     end
                  end
                  tcpq_pkg::FN_SEARCH: begin
                     if (!sts.empty) begin
                        cmd.rd_issue  = 1'b1;
                        cmd.idx_clear = 1'b1;
                        state_in      = tcpq_pkg::S_SCAN;
                     end
                  end
                  default: begin
                     state_in = tcpq_pkg::S_FINISH;
                  end
               endcase
            end
         end
         tcpq_pkg::S_DEQ: begin
            cmd.deq_commit = 1'b1;
            state_in       = tcpq_pkg::S_FINISH;
         end
         tcpq_pkg::S_SCAN: begin
            priority if (sts.match) begin
               cmd.set_found = 1'b1;
               state_in      = tcpq_pkg::S_FINISH;
            end else if (sts.scan_last) begin
               state_in = tcpq_pkg::S_FINISH;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_next  = 1'b1;
               cmd.idx_inc  = 1'b1;
            end
         end
         tcpq_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = tcpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tcpq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/three_class_packet_ring_queues_core.sv]
// top level: three priority-class packet ring queues with id search
//
// requests arrive on the req_ channel (valid/ready): func selects enqueue,
// dequeue or id search, queue_class selects the high, medium or low queue.
// every request yields exactly one response on the rsp_ channel carrying
// status, the dequeued packet, the search flag and the running size total.
// one request is in work at a time. enqueue and rejected requests pass through
// the exec and finish states before the response is loaded, dequeue through
// exec, deq and finish, and a search of a non-empty queue through exec, the
// scan state, which examines one entry at a time through the single read
// port of the entry memory, and finish. req_ready is high in idle, so the
// next request can be accepted in the cycle after the response is loaded.
// the response sits in an output register: a stalled receiver does not stop
// the next request from being accepted and worked on, but its response waits
// until the previous one is taken.
// reset empties all three queues and clears the total; no clearing pass runs
// over the entry memory, so the block accepts requests right after reset.
`timescale 1ns / 1ps
module three_class_packet_ring_queues_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tcpq_pkg::FUNC_W-1:0]         req_func,
   input  logic [tcpq_pkg::CLASS_W-1:0]        req_queue_class,
   input  logic [tcpq_pkg::ID_W-1:0]           req_packet_id,
   input  logic [tcpq_pkg::SIZE_W-1:0]         req_packet_size,
   input  logic signed [tcpq_pkg::PRIO_W-1:0]  req_packet_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [tcpq_pkg::ID_W-1:0]           rsp_out_id,
   output logic [tcpq_pkg::SIZE_W-1:0]         rsp_out_size,
   output logic signed [tcpq_pkg::PRIO_W-1:0]  rsp_out_priority,
   output logic                                rsp_found,
   output logic [tcpq_pkg::TOTAL_W-1:0]        rsp_occupied_total
);

   tcpq_pkg::cmd_type cmd;
   tcpq_pkg::sts_type sts;

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcpq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_func            (req_func),
      .req_queue_class     (req_queue_class),
      .req_packet_id       (req_packet_id),
      .req_packet_size     (req_packet_size),
      .req_packet_priority (req_packet_priority),
      .rsp_status          (rsp_status),
      .rsp_out_id          (rsp_out_id),
      .rsp_out_size        (rsp_out_size),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_found           (rsp_found),
      .rsp_occupied_total  (rsp_occupied_total)
   );

`ifndef SYNTH
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one still in work");

   a_reject_no_packet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != 2'(tcpq_pkg::STAT_OK)) |->
         (rsp_out_id == '0) && (rsp_out_size == '0) && !rsp_found)
      else $error("rejected request returned packet data");

   a_found_is_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |->
         (rsp_status == 2'(tcpq_pkg::STAT_OK)) && (rsp_out_size == '0))
      else $error("search hit with bad status or packet data");
`endif

endmodule

[dv/three_class_packet_ring_queues_core_test.sv]
// testbench for the three-class packet ring queues: random requests checked against a queue predictor
`timescale 1ns / 1ps
module three_class_packet_ring_queues_core_test;

   localparam int DEPTH       = 16;
   localparam int CLASS_COUNT = int'(tcpq_pkg::NUM_CLASSES);
   localparam int ITEMS       = 1000;
   localparam int MAX_REPORTS = 10;
   localparam int ID_W        = tcpq_pkg::ID_W;
   localparam int SIZE_W      = tcpq_pkg::SIZE_W;
   localparam int PRIO_W      = tcpq_pkg::PRIO_W;
   localparam int TOTAL_W     = tcpq_pkg::TOTAL_W;
   localparam int FUNC_W      = tcpq_pkg::FUNC_W;
   localparam int CLASS_W     = tcpq_pkg::CLASS_W;
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   typedef struct packed {
      tcpq_pkg::status_type status;
      logic [ID_W-1:0]      out_id;
      logic [SIZE_W-1:0]    out_size;
      logic [PRIO_W-1:0]    out_prio;
      logic                 found;
      logic [TOTAL_W-1:0]   total;
   } response_type;

   class ring_queue_scoreboard;
      response_type       expected_q[$];
      logic [ID_W-1:0]    slot_id   [CLASS_COUNT][DEPTH];
      logic [SIZE_W-1:0]  slot_size [CLASS_COUNT][DEPTH];
      logic [PRIO_W-1:0]  slot_tag  [CLASS_COUNT][DEPTH];
      int unsigned        head      [CLASS_COUNT];
      int unsigned        fill      [CLASS_COUNT];
      logic [TOTAL_W-1:0] total;
      int errors, checked;
      int enq_ok, deq_ok, searches, found_hits, full_hits, empty_hits, ignored;

      function new();
         foreach (head[c]) begin
            head[c] = 0;
            fill[c] = 0;
         end
         total = '0;
      endfunction

      function void note_request(logic [FUNC_W-1:0] fn, logic [CLASS_W-1:0] qc,
                                 logic [ID_W-1:0] pid, logic [SIZE_W-1:0] psz,
                                 logic [PRIO_W-1:0] ptag);
         response_type r;
         int unsigned  slot;
         r = '0;
         r.status = tcpq_pkg::STAT_OK;
         if (qc < tcpq_pkg::NUM_CLASSES && fn != FN_UNUSED) begin
            case (fn)
               tcpq_pkg::FN_ENQ: begin
                  if (fill[qc] >= DEPTH) begin
                     r.status = tcpq_pkg::STAT_FULL;
                     full_hits++;
                  end else begin
                     slot = (head[qc] + fill[qc]) % DEPTH;
                     slot_id[qc][slot]   = pid;
                     slot_size[qc][slot] = psz;
                     slot_tag[qc][slot]  = ptag;
                     fill[qc]++;
                     total += TOTAL_W'(psz);
                     enq_ok++;
                  end
               end
               tcpq_pkg::FN_DEQ: begin
                  if (fill[qc] == 0) begin
                     r.status = tcpq_pkg::STAT_EMPTY;
                     empty_hits++;
                  end else begin
                     slot = head[qc];
                     r.out_id   = slot_id[qc][slot];
                     r.out_size = slot_size[qc][slot];
                     r.out_prio = slot_tag[qc][slot];
                     total -= TOTAL_W'(slot_size[qc][slot]);
                     head[qc] = (head[qc] + 1) % DEPTH;
                     fill[qc]--;
                     deq_ok++;
                  end
               end
               default: begin
                  for (int unsigned i = 0; i < fill[qc]; i++)
                     if (slot_id[qc][(head[qc] + i) % DEPTH] == pid) r.found = 1'b1;
                  searches++;
                  if (r.found) found_hits++;
               end
            endcase
         end else begin
            ignored++;
         end
         r.total = total;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s differs, expected 0x%0h, got 0x%0h",
                        $time, field, want, got);
         end
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: response with no request outstanding", $time);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("status", TOTAL_W'(want.status), TOTAL_W'(got.status));
         compare_field("out_id", TOTAL_W'(want.out_id), TOTAL_W'(got.out_id));
         compare_field("out_size", TOTAL_W'(want.out_size), TOTAL_W'(got.out_size));
         compare_field("out_priority", TOTAL_W'(want.out_prio), TOTAL_W'(got.out_prio));
         compare_field("found", TOTAL_W'(want.found), TOTAL_W'(got.found));
         compare_field("occupied_total", want.total, got.total);
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [FUNC_W-1:0]          req_func = '0;
   logic [CLASS_W-1:0]         req_queue_class = '0;
   logic [ID_W-1:0]            req_packet_id = '0;
   logic [SIZE_W-1:0]          req_packet_size = '0;
   logic signed [PRIO_W-1:0]   req_packet_priority = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_status;
   logic [ID_W-1:0]            rsp_out_id;
   logic [SIZE_W-1:0]          rsp_out_size;
   logic signed [PRIO_W-1:0]   rsp_out_priority;
   logic                       rsp_found;
   logic [TOTAL_W-1:0]         rsp_occupied_total;

   ring_queue_scoreboard sb = new();
   bit calm = 1'b0;
   int sent = 0;

   three_class_packet_ring_queues_core #(.QUEUE_DEPTH(DEPTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_queue_class    (req_queue_class),
      .req_packet_id      (req_packet_id),
      .req_packet_size    (req_packet_size),
      .req_packet_priority(req_packet_priority),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_out_id         (rsp_out_id),
      .rsp_out_size       (rsp_out_size),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_found          (rsp_found),
      .rsp_occupied_total (rsp_occupied_total)
   );

   always #6 clock = ~clock;

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic issue(input logic [FUNC_W-1:0] fn, input logic [CLASS_W-1:0] qc,
                        input logic [ID_W-1:0] pid, input logic [SIZE_W-1:0] psz,
                        input logic [PRIO_W-1:0] ptag);
      int gap;
      req_func            <= fn;
      req_queue_class     <= qc;
      req_packet_id       <= pid;
      req_packet_size     <= psz;
      req_packet_priority <= ptag;
      req_valid           <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(fn, qc, pid, psz, ptag);
      sent++;
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // receiver side stalls
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = idle_gap();
         end
      end
   end

   initial begin
      response_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.status   = tcpq_pkg::status_type'(rsp_status);
            got.out_id   = rsp_out_id;
            got.out_size = rsp_out_size;
            got.out_prio = rsp_out_priority;
            got.found    = rsp_found;
            got.total    = rsp_occupied_total;
            sb.check_response(got);
         end
      end
   end

   initial begin
      int counted, enq_pct, r;
      logic [FUNC_W-1:0]  fn;
      logic [CLASS_W-1:0] qc, focus;
      logic [ID_W-1:0]    pid;
      counted = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queues, extremes, search hit and miss, unused codes
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_HIGH, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_MED, 16'hffff, 16'hffff, 3'b111);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_LOW, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_SEARCH, tcpq_pkg::CLASS_HIGH, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_ENQ, tcpq_pkg::CLASS_HIGH, 16'h0000, 16'h0000, 3'b111);
      issue(tcpq_pkg::FN_ENQ, tcpq_pkg::CLASS_HIGH, 16'hffff, 16'hffff, 3'b010);
      issue(tcpq_pkg::FN_ENQ, tcpq_pkg::CLASS_MED, 16'h1234, 16'hffff, 3'b100);
      issue(tcpq_pkg::FN_ENQ, tcpq_pkg::CLASS_LOW, 16'hffff, 16'h0001, 3'b011);
      issue(tcpq_pkg::FN_SEARCH, tcpq_pkg::CLASS_HIGH, 16'hffff, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_SEARCH, tcpq_pkg::CLASS_HIGH, 16'h0005, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_SEARCH, tcpq_pkg::CLASS_MED, 16'h1234, 16'hffff, 3'b111);
      issue(FN_UNUSED, tcpq_pkg::CLASS_HIGH, 16'h0000, 16'h0007, 3'b001);
      issue(tcpq_pkg::FN_ENQ, tcpq_pkg::NUM_CLASSES, 16'habcd, 16'hffff, 3'b010);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::NUM_CLASSES, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_SEARCH, tcpq_pkg::NUM_CLASSES, 16'hffff, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_HIGH, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_HIGH, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_MED, 16'h0000, 16'h0000, 3'b000);
      issue(tcpq_pkg::FN_DEQ, tcpq_pkg::CLASS_LOW, 16'h0000, 16'h0000, 3'b000);

      // each phase puts a randomly chosen fill or drain pressure on one favored queue
      for (int phase = 0; counted < ITEMS; phase++) begin
         calm = (phase % 4 == 3);
         case ($urandom_range(0, 3))
            0: enq_pct = 15;
            1: enq_pct = 45;
            2: enq_pct = 60;
            default: enq_pct = 90;
         endcase
         focus = CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
         repeat (40) begin
            r = $urandom_range(0, 99);
            if (r < 4) fn = FN_UNUSED;
            else if (r < 22) fn = tcpq_pkg::FN_SEARCH;
            else fn = ($urandom_range(0, 99) < enq_pct) ? tcpq_pkg::FN_ENQ : tcpq_pkg::FN_DEQ;
            r = $urandom_range(0, 99);
            if (r < 4) qc = tcpq_pkg::NUM_CLASSES;
            else if (r < 64) qc = focus;
            else qc = CLASS_W'($urandom_range(0, CLASS_COUNT - 1));
            pid = ($urandom_range(0, 99) < 60) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
            issue(fn, qc, pid, SIZE_W'($urandom), PRIO_W'($urandom));
            if (fn != FN_UNUSED && qc < tcpq_pkg::NUM_CLASSES) counted++;
         end
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);

      $display("ran %0d requests: %0d enqueued, %0d dequeued, %0d searches with %0d hits",
               sent, sb.enq_ok, sb.deq_ok, sb.searches, sb.found_hits);
      $display("%0d ignored, full refusals %0d, empty refusals %0d, checked %0d, errors %0d",
               sb.ignored, sb.full_hits, sb.empty_hits, sb.checked, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timed out with %0d responses outstanding", sb.expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
hdl/tcpq_pkg.sv
hdl/tcpq_ram.sv
hdl/tcpq_dp.sv
hdl/tcpq_ctrl.sv
hdl/three_class_packet_ring_queues_core.sv
dv/three_class_packet_ring_queues_core_test.sv
